// File: src/sclk_pkg.sv
// ----------------------------------------------------------------------------
// sclk_pkg
// Shared types, constants and time arithmetic for the settable 24-hour clock.
// ----------------------------------------------------------------------------
`default_nettype none

package sclk_pkg;

    localparam int KindW   = 2;
    localparam int ButtonW = 3;
    localparam int SwitchW = 4;
    localparam int HourW   = 5;
    localparam int MinW    = 6;
    localparam int SecW    = 6;
    localparam int CountW  = 8;
    localparam int CfgW    = 8;
    localparam int PaddrW  = 4;
    localparam int PdataW  = 32;

    localparam logic [HourW-1:0]   HourMax    = 5'd23;
    localparam logic [MinW-1:0]    MinMax     = 6'd59;
    localparam logic [SecW-1:0]    SecMax     = 6'd59;
    localparam logic [CountW-1:0]  CountSat   = 8'hFF;
    localparam logic [SwitchW-1:0] SwitchNone = 4'h8;

    localparam logic [CfgW-1:0] DebounceReset    = 8'd3;
    localparam logic [CfgW-1:0] RepeatStartReset = 8'd50;
    localparam logic [CfgW-1:0] RepeatPerReset   = 8'd10;
    localparam logic [CfgW-1:0] TicksPerSecReset = 8'd100;

    typedef enum logic [KindW-1:0] {
        KIND_TICK   = 2'd0,
        KIND_BUTTON = 2'd1,
        KIND_SWITCH = 2'd2,
        KIND_UNUSED = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } t_dir;

    typedef enum logic [1:0] {
        REG_DEBOUNCE     = 2'd0,
        REG_REPEAT_START = 2'd1,
        REG_REPEAT_PER   = 2'd2,
        REG_TICKS_PER_S  = 2'd3
    } t_reg_addr;

    typedef struct packed {
        logic [HourW-1:0] hours;
        logic [MinW-1:0]  minutes;
        logic [SecW-1:0]  seconds;
    } t_time;

    localparam t_time ShownReset = '{hours: HourMax, minutes: MinMax, seconds: SecMax};

    // Step a minute or second field by one, wrapping at 60 with no carry.
    function automatic logic [SecW-1:0] step60(input logic [SecW-1:0] v, input t_dir dir);
        logic [SecW-1:0] r;
        r = v;
        if (dir == DIR_UP) begin
            r = (v >= SecMax) ? '0 : v + 6'd1;
        end else if (dir == DIR_DOWN) begin
            r = (v == '0) ? SecMax : v - 6'd1;
        end
        return r;
    endfunction

    function automatic logic [HourW-1:0] step24(input logic [HourW-1:0] v, input t_dir dir);
        logic [HourW-1:0] r;
        r = v;
        if (dir == DIR_UP) begin
            r = (v >= HourMax) ? '0 : v + 5'd1;
        end else if (dir == DIR_DOWN) begin
            r = (v == '0) ? HourMax : v - 5'd1;
        end
        return r;
    endfunction

    function automatic t_time apply_step(input t_time t, input logic [ButtonW-1:0] held,
                                         input t_dir dir);
        t_time r;
        r = t;
        if (held[0]) begin
            r.seconds = step60(t.seconds, dir);
        end
        if (held[1]) begin
            r.minutes = step60(t.minutes, dir);
        end
        if (held[2]) begin
            r.hours = step24(t.hours, dir);
        end
        return r;
    endfunction

    // Seconds going below zero also restart the subsecond count.
    function automatic logic sec_underflow(input t_time t, input logic [ButtonW-1:0] held,
                                           input t_dir dir);
        return held[0] && (dir == DIR_DOWN) && (t.seconds == '0);
    endfunction

    function automatic t_time advance_second(input t_time t);
        t_time r;
        r = t;
        if (t.seconds >= SecMax) begin
            r.seconds = '0;
            if (t.minutes >= MinMax) begin
                r.minutes = '0;
                r.hours   = (t.hours >= HourMax) ? '0 : t.hours + 5'd1;
            end else begin
                r.minutes = t.minutes + 6'd1;
            end
        end else begin
            r.seconds = t.seconds + 6'd1;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/sclk_if.sv
// ----------------------------------------------------------------------------
// sclk_in_if / sclk_out_if
// Valid/ready channels carrying clock events in and displayed time out.
// ----------------------------------------------------------------------------
`default_nettype none

interface sclk_in_if;
    logic                            valid;
    logic                            ready;
    logic [sclk_pkg::KindW-1:0]      kind;
    logic [sclk_pkg::ButtonW-1:0]    buttons;
    logic [sclk_pkg::SwitchW-1:0]    switches;

    modport source (output valid, kind, buttons, switches, input ready);
    modport sink   (input valid, kind, buttons, switches, output ready);
endinterface

interface sclk_out_if;
    logic                            valid;
    logic                            ready;
    logic [sclk_pkg::HourW-1:0]      hours;
    logic [sclk_pkg::MinW-1:0]       minutes;
    logic [sclk_pkg::SecW-1:0]       seconds;
    logic                            shown_changed;

    modport source (output valid, hours, minutes, seconds, shown_changed, input ready);
    modport sink   (input valid, hours, minutes, seconds, shown_changed, output ready);
endinterface

`default_nettype wire

// File: src/settable_clock_with_button_repeat.sv
// ----------------------------------------------------------------------------
// settable_clock_with_button_repeat
// 24-hour clock with debounced, auto-repeating set buttons and run control.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake          Payload
//  i_in     in   valid/ready        kind, buttons, switches
//  o_out    out  valid/ready        hours, minutes, seconds, shown_changed
//  APB      in   psel/penable/pready  4 x 8-bit registers at 0x0, 0x4, 0x8, 0xC
//
//  One request per cycle: the whole update is one pass of counter and
//  compare logic from the state registers into the result register.
//  A result is registered and appears in the cycle after its request is accepted.
//  The input stays ready while a held result is taken in the same cycle;
//  it stalls only while the result register is full and o_out.ready is low.
//  Reset (synchronous, active low) clears time and control state.
// ----------------------------------------------------------------------------
`default_nettype none

module settable_clock_with_button_repeat (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    sclk_in_if.sink                        i_in,
    sclk_out_if.source                     o_out,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [sclk_pkg::PaddrW-1:0]    paddr,
    input  wire  [sclk_pkg::PdataW-1:0]    pwdata,
    output logic [sclk_pkg::PdataW-1:0]    prdata,
    output logic                           pready
);
    import sclk_pkg::*;

    logic [CfgW-1:0]    r_debounce, r_rep_start, r_rep_per, r_tps;
    t_time              r_time, n_time;
    t_time              r_shown, n_shown;
    logic [CountW-1:0]  r_sub, n_sub;
    logic [CountW-1:0]  r_hold, n_hold;
    logic [CountW-1:0]  r_rep, n_rep;
    logic               r_first, n_first;
    logic [ButtonW-1:0] r_held, n_held;
    logic [SwitchW-1:0] r_last_sw, n_last_sw;
    t_dir               r_dir, n_dir;
    logic               r_run, n_run;
    logic               n_changed;

    logic               r_out_valid;
    t_time              r_out_time;
    logic               r_out_changed;

    logic               in_acc;
    t_kind              kind;
    t_reg_addr          reg_sel;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign reg_sel = t_reg_addr'(paddr[3:2]);

    always_comb begin
        case (reg_sel)
            REG_DEBOUNCE:     prdata = PdataW'(r_debounce);
            REG_REPEAT_START: prdata = PdataW'(r_rep_start);
            REG_REPEAT_PER:   prdata = PdataW'(r_rep_per);
            REG_TICKS_PER_S:  prdata = PdataW'(r_tps);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= DebounceReset;
            r_rep_start <= RepeatStartReset;
            r_rep_per   <= RepeatPerReset;
            r_tps       <= TicksPerSecReset;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_DEBOUNCE:     r_debounce  <= pwdata[CfgW-1:0];
                REG_REPEAT_START: r_rep_start <= pwdata[CfgW-1:0];
                REG_REPEAT_PER:   r_rep_per   <= pwdata[CfgW-1:0];
                REG_TICKS_PER_S:  r_tps       <= pwdata[CfgW-1:0];
                default:          r_tps       <= r_tps;
            endcase
        end
    end

    // ---------------- request handshake ----------------
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;
    assign kind       = t_kind'(i_in.kind);

    // ---------------- next-state logic ----------------
    always_comb begin
        t_time t_adv;
        t_time t_s1;
        logic  step1;
        logic  step2;
        logic  [CountW-1:0] rep_inc;

        n_time    = r_time;
        n_shown   = r_shown;
        n_sub     = r_sub;
        n_hold    = r_hold;
        n_rep     = r_rep;
        n_first   = r_first;
        n_held    = r_held;
        n_last_sw = r_last_sw;
        n_dir     = r_dir;
        n_run     = r_run;
        n_changed = 1'b0;
        t_adv     = r_time;
        t_s1      = r_time;
        step1     = 1'b0;
        step2     = 1'b0;
        rep_inc   = r_rep + 8'd1;

        case (kind)
            KIND_TICK: begin
                n_hold = (r_hold == CountSat) ? CountSat : r_hold + 8'd1;
                n_sub  = r_sub + 8'd1;
                if (r_run && (n_sub >= r_tps)) begin
                    n_sub = '0;
                    t_adv = advance_second(r_time);
                end
                step1 = (n_hold >= r_debounce) && !r_first;
                t_s1  = t_adv;
                if (step1) begin
                    if (sec_underflow(t_adv, r_held, r_dir)) begin
                        n_sub = '0;
                    end
                    t_s1    = apply_step(t_adv, r_held, r_dir);
                    n_first = 1'b1;
                end
                n_time = t_s1;
                if (n_hold >= r_rep_start) begin
                    n_rep = rep_inc;
                    step2 = rep_inc >= r_rep_per;
                    if (step2) begin
                        if (sec_underflow(t_s1, r_held, r_dir)) begin
                            n_sub = '0;
                        end
                        n_time = apply_step(t_s1, r_held, r_dir);
                        n_rep  = '0;
                    end
                end
                if (n_time != r_shown) begin
                    n_changed = 1'b1;
                    n_shown   = n_time;
                end
            end
            KIND_BUTTON: begin
                n_held  = i_in.buttons;
                n_first = 1'b0;
                n_hold  = '0;
            end
            KIND_SWITCH: begin
                if (i_in.switches != r_last_sw) begin
                    n_last_sw = i_in.switches;
                    n_dir     = i_in.switches[0] ? DIR_UP : DIR_DOWN;
                    n_run     = i_in.switches[1];
                    n_sub     = '0;
                end
            end
            default: begin
                n_changed = 1'b0;
            end
        endcase
    end

    // ---------------- state and result registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time      <= '0;
            r_shown     <= ShownReset;
            r_sub       <= '0;
            r_hold      <= '0;
            r_rep       <= '0;
            r_first     <= 1'b0;
            r_held      <= '0;
            r_last_sw   <= SwitchNone;
            r_dir       <= DIR_NONE;
            r_run       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_time      <= n_time;
                r_shown     <= n_shown;
                r_sub       <= n_sub;
                r_hold      <= n_hold;
                r_rep       <= n_rep;
                r_first     <= n_first;
                r_held      <= n_held;
                r_last_sw   <= n_last_sw;
                r_dir       <= n_dir;
                r_run       <= n_run;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_time    <= n_time;
            r_out_changed <= n_changed;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.hours         = r_out_time.hours;
    assign o_out.minutes       = r_out_time.minutes;
    assign o_out.seconds       = r_out_time.seconds;
    assign o_out.shown_changed = r_out_changed;

`ifndef SYNTHESIS
    a_acc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> r_out_valid)
        else $error("accepted request produced no result");

    a_button_clears_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.kind == KIND_BUTTON) |=> (r_hold == '0 && !r_first))
        else $error("button request did not restart debounce");

    a_switch_sets_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.kind == KIND_SWITCH && i_in.switches != r_last_sw)
        |=> (r_run == $past(i_in.switches[1])))
        else $error("run enable does not follow new switch state");

    a_tick_updates_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.kind == KIND_TICK)
        |=> (r_shown == r_out_time && r_out_time == r_time))
        else $error("shown time not tracked after tick");
`endif

endmodule

`default_nettype wire
